### rtl/cdp_pkg.sv
package cdp_pkg;

    // Field widths of the two streaming words
    localparam int DATA_WIDTH = 16;
    localparam int OPCODE_W   = 2;
    localparam int ADDRESS_W  = 16;
    localparam int RESULT_W   = 32;
    localparam int CELL_W     = 9;
    localparam int CURVE_W    = 6;
    localparam int ELEMENT_W  = 8;
    localparam int ACC_W      = 48;

    // Opcodes of an input word; the fourth code is unused and dropped
    localparam logic [OPCODE_W-1:0] OP_LOAD_WEIGHT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_LOAD_BIAS   = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_DATA        = 2'd2;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_SHARE_WEIGHTS   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CELLS_PER_SIDE  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_CURVES_PER_CELL = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DOT_LENGTH      = 2'd3;

    typedef struct packed {
        logic [OPCODE_W-1:0]          opcode;
        logic [ADDRESS_W-1:0]         address;
        logic signed [DATA_WIDTH-1:0] value;
    } item_t;

    typedef struct packed {
        logic signed [RESULT_W-1:0] dot_result;
        logic [CELL_W-1:0]          cell_index;
        logic [CURVE_W-1:0]         curve_index;
        logic                       last_of_sample;
    } result_t;

endpackage

### rtl/curve_dot_product_layer_forward.sv
// Channel  | Direction | Handshake                  | Word
// ---------+-----------+----------------------------+---------------------------------
// item     | in        | item_valid / item_stall    | opcode, address, value
// result   | out       | result_valid / result_stall| dot_result, cell/curve, last flag
// cfg      | in        | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
// One word is taken every cycle while item_stall is low; the last element of a curve
// passes through seven register stages to its result (input capture, slot multiply,
// address multiply, memory read, data multiply, accumulate, bias add and saturate
// into the output register).
// Reset clears counters, accumulator and stage valids and sets the configuration to
// its defaults; the weight and bias memories are not cleared.
// A stalled result stops only the stages behind a full stage; empty stages still fill.
module curve_dot_product_layer_forward
    import cdp_pkg::*;
#(
    parameter int WEIGHT_DEPTH = 65536,
    parameter int BIAS_DEPTH   = 4096,
    parameter int FRAC_BITS    = 8
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  item_t                  item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output result_t                result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int SLOT_W   = 15;
    localparam int WADDR_W  = 24;
    localparam int BADDR_W  = 16;
    localparam int WIDX_W   = $clog2(WEIGHT_DEPTH);
    localparam int BIDX_W   = $clog2(BIAS_DEPTH);
    localparam int PROD_W   = 2 * DATA_WIDTH;
    localparam int SUM_W    = ACC_W + 2;
    localparam int CELLS_W  = 10;
    localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(2147483647);
    localparam logic signed [SUM_W-1:0] SAT_MIN = -SAT_MAX - SUM_W'(1);

    typedef struct packed {
        logic [CELL_W-1:0]  cell_idx;
        logic [CURVE_W-1:0] curve;
        logic               last_el;
        logic               last_sample;
    } tag_t;

    // Configuration registers
    logic                  share_reg;
    logic [3:0]            side_reg;
    logic [6:0]            curves_reg;
    logic [8:0]            dotlen_reg;

    // Position counters
    logic [ELEMENT_W-1:0]  element_reg;
    logic [CURVE_W-1:0]    curve_reg;
    logic [CELL_W-1:0]     cell_reg;

    // Stage 1: captured word and its position
    logic                  v1_reg;
    logic [OPCODE_W-1:0]   s1_op_reg;
    logic [ADDRESS_W-1:0]  s1_addr_reg;
    logic [DATA_WIDTH-1:0] s1_value_reg;
    logic [ELEMENT_W-1:0]  s1_element_reg;
    tag_t                  s1_tag_reg;

    // Stage 2: slot
    logic                  v2_reg;
    logic [OPCODE_W-1:0]   s2_op_reg;
    logic [ADDRESS_W-1:0]  s2_addr_reg;
    logic [DATA_WIDTH-1:0] s2_value_reg;
    logic [ELEMENT_W-1:0]  s2_element_reg;
    logic [SLOT_W-1:0]     s2_slot_reg;
    tag_t                  s2_tag_reg;

    // Stage 3: memory addresses
    logic                  v3_reg;
    logic [OPCODE_W-1:0]   s3_op_reg;
    logic [WADDR_W-1:0]    s3_waddr_reg;
    logic [BADDR_W-1:0]    s3_baddr_reg;
    logic                  s3_w_ok_reg;
    logic                  s3_b_ok_reg;
    logic [DATA_WIDTH-1:0] s3_value_reg;
    tag_t                  s3_tag_reg;

    // Stage 4: memory read data
    logic                  v4_reg;
    logic [DATA_WIDTH-1:0] s4_value_reg;
    logic [DATA_WIDTH-1:0] w_rd_reg;
    logic [DATA_WIDTH-1:0] b_rd_reg;
    logic                  s4_w_ok_reg;
    logic                  s4_b_ok_reg;
    tag_t                  s4_tag_reg;

    // Stage 5: product
    logic                     v5_reg;
    logic signed [PROD_W-1:0] s5_prod_reg;
    logic signed [DATA_WIDTH-1:0] s5_bias_reg;
    tag_t                     s5_tag_reg;

    // Stage 6: finished dot product
    logic                     v6_reg;
    logic signed [ACC_W-1:0]  s6_acc_reg;
    logic signed [DATA_WIDTH-1:0] s6_bias_reg;
    tag_t                     s6_tag_reg;

    logic signed [ACC_W-1:0]  acc_reg;

    // Output register
    logic                  out_valid_reg;
    result_t               out_reg;

    // Memories
    logic [DATA_WIDTH-1:0] weight_mem [WEIGHT_DEPTH];
    logic [DATA_WIDTH-1:0] bias_mem   [BIAS_DEPTH];

    logic                  en1, en2, en3, en4, en5, en6, en_out;
    logic                  item_acc;
    logic                  is_data_in;
    logic [8:0]            len_c;
    logic [6:0]            curves_c;
    logic [CELLS_W-1:0]    cells_c;
    logic                  last_el_c, last_cv_c, last_cl_c;
    logic [15:0]           slot_wide;
    logic [SLOT_W-1:0]     slot_next;
    logic [WADDR_W-1:0]    slot_ext;
    logic [WADDR_W-1:0]    waddr_next;
    logic [BADDR_W-1:0]    baddr_next;
    logic                  s2_is_data;
    logic [WIDX_W-1:0]     widx;
    logic [BIDX_W-1:0]     bidx;
    logic signed [DATA_WIDTH-1:0] w_eff;
    logic signed [DATA_WIDTH-1:0] b_eff;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [ACC_W-1:0]  acc_sum;
    logic signed [SUM_W-1:0]  sum_full;
    logic signed [RESULT_W-1:0] sat_sum;

    // Stage enables: a stage loads when it is empty or its content moves on
    always_comb
    begin
        en_out = !out_valid_reg || !result_stall;
        en6    = !v6_reg || en_out;
        en5    = !v5_reg || en6;
        en4    = !v4_reg || en5;
        en3    = !v3_reg || en4;
        en2    = !v2_reg || en3;
        en1    = !v1_reg || en2;
    end

    assign item_stall   = !en1;
    assign item_acc     = item_valid && !item_stall;
    assign is_data_in   = (item.opcode == OP_DATA);
    assign cfg_ready    = 1'b1;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    // Clamp configuration to its legal range
    always_comb
    begin
        if (dotlen_reg == 9'd0)
        begin
            len_c = 9'd1;
        end
        else if (dotlen_reg > 9'd256)
        begin
            len_c = 9'd256;
        end
        else
        begin
            len_c = dotlen_reg;
        end

        if (curves_reg == 7'd0)
        begin
            curves_c = 7'd1;
        end
        else if (curves_reg > 7'd64)
        begin
            curves_c = 7'd64;
        end
        else
        begin
            curves_c = curves_reg;
        end

        case (side_reg)
            4'd0, 4'd1: cells_c = CELLS_W'(1);
            4'd2:       cells_c = CELLS_W'(8);
            4'd3:       cells_c = CELLS_W'(27);
            4'd4:       cells_c = CELLS_W'(64);
            4'd5:       cells_c = CELLS_W'(125);
            4'd6:       cells_c = CELLS_W'(216);
            4'd7:       cells_c = CELLS_W'(343);
            default:    cells_c = CELLS_W'(512);
        endcase
    end

    // Position flags of the incoming element
    always_comb
    begin
        last_el_c = ({1'b0, element_reg} + 9'd1) >= len_c;
        last_cv_c = ({1'b0, curve_reg} + 7'd1) >= curves_c;
        last_cl_c = ({1'b0, cell_reg} + CELLS_W'(1)) >= cells_c;
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            share_reg  <= 1'b1;
            side_reg   <= 4'd4;
            curves_reg <= 7'd8;
            dotlen_reg <= 9'd16;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_SHARE_WEIGHTS:   share_reg  <= cfg_data[0];
                CFG_CELLS_PER_SIDE:  side_reg   <= cfg_data[3:0];
                CFG_CURVES_PER_CELL: curves_reg <= cfg_data[6:0];
                CFG_DOT_LENGTH:      dotlen_reg <= cfg_data[8:0];
                default:             share_reg  <= share_reg;
            endcase
        end
    end

    // Advance element, curve and cell counters on each data word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            element_reg <= '0;
            curve_reg   <= '0;
            cell_reg    <= '0;
        end
        else if (item_acc && is_data_in)
        begin
            if (!last_el_c)
            begin
                element_reg <= element_reg + ELEMENT_W'(1);
            end
            else
            begin
                element_reg <= '0;
                if (last_cv_c)
                begin
                    curve_reg <= '0;
                    cell_reg  <= last_cl_c ? '0 : cell_reg + CELL_W'(1);
                end
                else
                begin
                    curve_reg <= curve_reg + CURVE_W'(1);
                end
            end
        end
    end

    // Stage valid bits; unused opcodes drop at entry, loads at the memory stage, unfinished curves before stage 6
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= item_acc
                          && (item.opcode inside {OP_LOAD_WEIGHT, OP_LOAD_BIAS, OP_DATA});
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg && (s3_op_reg == OP_DATA);
            end
            if (en5)
            begin
                v5_reg <= v4_reg;
            end
            if (en6)
            begin
                v6_reg <= v5_reg && s5_tag_reg.last_el;
            end
            if (en_out)
            begin
                out_valid_reg <= v6_reg;
            end
        end
    end

    // Stage 1: capture word and position
    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_op_reg               <= item.opcode;
            s1_addr_reg             <= item.address;
            s1_value_reg            <= item.value;
            s1_element_reg          <= element_reg;
            s1_tag_reg.cell_idx     <= cell_reg;
            s1_tag_reg.curve        <= curve_reg;
            s1_tag_reg.last_el      <= last_el_c;
            s1_tag_reg.last_sample  <= last_cv_c && last_cl_c;
        end
    end

    // Stage 2: slot of the current curve
    always_comb
    begin
        slot_wide = 16'(s1_tag_reg.cell_idx) * 16'(curves_c) + 16'(s1_tag_reg.curve);
        slot_next = share_reg ? SLOT_W'(s1_tag_reg.curve) : slot_wide[SLOT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_op_reg      <= s1_op_reg;
            s2_addr_reg    <= s1_addr_reg;
            s2_value_reg   <= s1_value_reg;
            s2_element_reg <= s1_element_reg;
            s2_slot_reg    <= slot_next;
            s2_tag_reg     <= s1_tag_reg;
        end
    end

    // Stage 3: weight and bias addresses, loads use their own address
    always_comb
    begin
        s2_is_data = (s2_op_reg == OP_DATA);
        slot_ext   = WADDR_W'(s2_slot_reg);
        if (s2_is_data)
        begin
            waddr_next = slot_ext * WADDR_W'(len_c) + WADDR_W'(s2_element_reg);
            baddr_next = BADDR_W'(s2_slot_reg);
        end
        else
        begin
            waddr_next = WADDR_W'(s2_addr_reg);
            baddr_next = s2_addr_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_op_reg    <= s2_op_reg;
            s3_waddr_reg <= waddr_next;
            s3_baddr_reg <= baddr_next;
            s3_w_ok_reg  <= {1'b0, waddr_next} < (WADDR_W + 1)'(WEIGHT_DEPTH);
            s3_b_ok_reg  <= {1'b0, baddr_next} < (BADDR_W + 1)'(BIAS_DEPTH);
            s3_value_reg <= s2_value_reg;
            s3_tag_reg   <= s2_tag_reg;
        end
    end

    // Stage 4: write loads, read weight and bias for data words
    assign widx = s3_waddr_reg[WIDX_W-1:0];
    assign bidx = s3_baddr_reg[BIDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            if (v3_reg && s3_op_reg == OP_LOAD_WEIGHT && s3_w_ok_reg)
            begin
                weight_mem[widx] <= s3_value_reg;
            end
            w_rd_reg <= weight_mem[widx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            if (v3_reg && s3_op_reg == OP_LOAD_BIAS && s3_b_ok_reg)
            begin
                bias_mem[bidx] <= s3_value_reg;
            end
            b_rd_reg <= bias_mem[bidx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            s4_value_reg <= s3_value_reg;
            s4_w_ok_reg  <= s3_w_ok_reg;
            s4_b_ok_reg  <= s3_b_ok_reg;
            s4_tag_reg   <= s3_tag_reg;
        end
    end

    // Stage 5: multiply; out-of-range reads count as zero
    always_comb
    begin
        w_eff     = s4_w_ok_reg ? signed'(w_rd_reg) : '0;
        b_eff     = s4_b_ok_reg ? signed'(b_rd_reg) : '0;
        prod_next = signed'(s4_value_reg) * w_eff;
    end

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            s5_prod_reg <= prod_next;
            s5_bias_reg <= b_eff;
            s5_tag_reg  <= s4_tag_reg;
        end
    end

    // Stage 6: accumulate, clear after the last element of a curve
    assign acc_sum = acc_reg + ACC_W'(s5_prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (v5_reg && en6)
        begin
            acc_reg <= s5_tag_reg.last_el ? '0 : acc_sum;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en6)
        begin
            s6_acc_reg  <= acc_sum;
            s6_bias_reg <= s5_bias_reg;
            s6_tag_reg  <= s5_tag_reg;
        end
    end

    // Output: add shifted bias and saturate to 32 bits
    always_comb
    begin
        sum_full = SUM_W'(s6_acc_reg) + (SUM_W'(s6_bias_reg) <<< FRAC_BITS);
        if (sum_full > SAT_MAX)
        begin
            sat_sum = RESULT_W'(SAT_MAX);
        end
        else if (sum_full < SAT_MIN)
        begin
            sat_sum = RESULT_W'(SAT_MIN);
        end
        else
        begin
            sat_sum = sum_full[RESULT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            out_reg.dot_result     <= sat_sum;
            out_reg.cell_index     <= s6_tag_reg.cell_idx;
            out_reg.curve_index    <= s6_tag_reg.curve;
            out_reg.last_of_sample <= s6_tag_reg.last_sample;
        end
    end

    // Accumulator starts from zero after each finished curve
    assert property (@(posedge clk) disable iff (!rst_n)
        (v5_reg && en6 && s5_tag_reg.last_el) |=> (acc_reg == '0))
        else $error("accumulator not cleared after last element");

    // Only a finished curve enters the final stage
    assert property (@(posedge clk) disable iff (!rst_n)
        (v5_reg && en6 && !s5_tag_reg.last_el) |=> !v6_reg)
        else $error("partial dot product reached the final stage");

    // Input is held back only when the whole pipeline is blocked by the output
    assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (out_valid_reg && result_stall && v1_reg && v6_reg))
        else $error("input stalled while a stage was free");

endmodule

### sim/curve_dot_product_checker.sv
`timescale 1ns / 100ps

module curve_dot_product_checker
    import cdp_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    input  logic                   item_stall,
    input  item_t                  item,
    input  logic                   result_valid,
    input  logic                   result_stall,
    input  result_t                result,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output int                     fail_count,
    output int                     outstanding
);

    localparam int WEIGHT_DEPTH = 65536;
    localparam int BIAS_DEPTH   = 4096;
    localparam int FRAC_BITS    = 8;
    localparam int MAX_REPORTS  = 10;

    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;

    logic signed [DATA_WIDTH-1:0] weight_mem [WEIGHT_DEPTH];
    logic signed [DATA_WIDTH-1:0] bias_mem [BIAS_DEPTH];
    logic [ACC_W-1:0]             dot_acc;
    int unsigned                  element_pos;
    int unsigned                  curve_pos;
    int unsigned                  cell_pos;

    logic       share_mode;
    logic [3:0] side_reg;
    logic [6:0] curves_reg;
    logic [8:0] length_reg;

    result_t expected_dots [$];

    function automatic int unsigned bound(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo)
        begin
            return lo;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    // Multiply one data word into the sum; queue the curve's result when it closes
    task automatic accumulate_element(input logic signed [DATA_WIDTH-1:0] x);
        int unsigned len_eff;
        int unsigned curves_eff;
        int unsigned side_eff;
        int unsigned cells_eff;
        int unsigned slot;
        int unsigned waddr;
        logic signed [DATA_WIDTH-1:0] w;
        logic signed [DATA_WIDTH-1:0] b;
        longint prod;
        longint sum;
        logic last_curve;
        logic last_cell;
        result_t r;

        len_eff    = bound(32'(length_reg), 1, 256);
        curves_eff = bound(32'(curves_reg), 1, 64);
        side_eff   = bound(32'(side_reg), 1, 8);
        cells_eff  = side_eff * side_eff * side_eff;

        slot  = share_mode ? curve_pos : cell_pos * curves_eff + curve_pos;
        waddr = slot * len_eff + element_pos;
        w     = (waddr < WEIGHT_DEPTH) ? weight_mem[waddr] : '0;

        prod    = longint'(x) * longint'(w);
        dot_acc = dot_acc + prod[ACC_W-1:0];

        if (element_pos + 1 < len_eff)
        begin
            element_pos = (element_pos + 1) & 32'hFF;
        end
        else
        begin
            // Close the curve: add the scaled bias and clip to 32 bits
            b   = (slot < BIAS_DEPTH) ? bias_mem[slot] : '0;
            sum = longint'($signed(dot_acc)) + (longint'(b) <<< FRAC_BITS);
            if (sum > SAT_HI)
            begin
                sum = SAT_HI;
            end
            if (sum < SAT_LO)
            begin
                sum = SAT_LO;
            end

            last_curve = (curve_pos + 1 >= curves_eff);
            last_cell  = (cell_pos + 1 >= cells_eff);

            r.dot_result     = sum[RESULT_W-1:0];
            r.cell_index     = cell_pos[CELL_W-1:0];
            r.curve_index    = curve_pos[CURVE_W-1:0];
            r.last_of_sample = last_curve && last_cell;
            expected_dots.insert(expected_dots.size(), r);

            dot_acc     = '0;
            element_pos = 0;
            if (last_curve)
            begin
                curve_pos = 0;
                cell_pos  = last_cell ? 0 : ((cell_pos + 1) & 32'h1FF);
            end
            else
            begin
                curve_pos = (curve_pos + 1) & 32'h3F;
            end
        end
    endtask

    task automatic note_failure(input string what, input result_t e, input result_t a);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
        begin
            $write("%s: expected result=%0d cell=%0d curve=%0d last=%0b, ",
                   what, e.dot_result, e.cell_index, e.curve_index, e.last_of_sample);
            $display("got result=%0d cell=%0d curve=%0d last=%0b",
                     a.dot_result, a.cell_index, a.curve_index, a.last_of_sample);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t e;
        if (!rst_n)
        begin
            dot_acc     = '0;
            element_pos = 0;
            curve_pos   = 0;
            cell_pos    = 0;
            share_mode  = 1'b1;
            side_reg    = 4'd4;
            curves_reg  = 7'd8;
            length_reg  = 9'd16;
            fail_count  = 0;
            expected_dots.delete();
        end
        else
        begin
            // Compare an outgoing word with the oldest expectation
            if (result_valid && !result_stall)
            begin
                if (expected_dots.size() == 0)
                begin
                    note_failure("dot result with nothing expected", '0, result);
                end
                else
                begin
                    e = expected_dots.pop_front();
                    if (result.dot_result !== e.dot_result
                        || result.cell_index !== e.cell_index
                        || result.curve_index !== e.curve_index
                        || result.last_of_sample !== e.last_of_sample)
                    begin
                        note_failure("dot mismatch", e, result);
                    end
                end
            end

            // Track register writes
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SHARE_WEIGHTS:   share_mode = cfg_data[0];
                    CFG_CELLS_PER_SIDE:  side_reg   = cfg_data[3:0];
                    CFG_CURVES_PER_CELL: curves_reg = cfg_data[6:0];
                    CFG_DOT_LENGTH:      length_reg = cfg_data[8:0];
                    default: ;
                endcase
            end

            // Apply an incoming word; drop the unused opcode
            if (item_valid && !item_stall)
            begin
                case (item.opcode)
                    OP_LOAD_WEIGHT:
                    begin
                        weight_mem[item.address] = item.value;
                    end
                    OP_LOAD_BIAS:
                    begin
                        if (item.address < BIAS_DEPTH)
                        begin
                            bias_mem[item.address] = item.value;
                        end
                    end
                    OP_DATA:
                    begin
                        accumulate_element(item.value);
                    end
                    default: ;
                endcase
            end
        end
        outstanding = expected_dots.size();
    end

endmodule

### sim/curve_dot_product_layer_forward_tb.sv
`timescale 1ns / 100ps

module curve_dot_product_layer_forward_tb;
    import cdp_pkg::*;

    localparam int WEIGHT_DEPTH  = 65536;
    localparam int BIAS_DEPTH    = 4096;
    localparam int WORD_TARGET   = 1350;
    localparam int SETTLE_CYCLES = 20;
    localparam int CYCLE_LIMIT   = 400000;

    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    localparam int RX_FREE  = 0;
    localparam int RX_LIGHT = 1;
    localparam int RX_HEAVY = 2;

    logic                   clk;
    logic                   rst_n;
    logic                   item_valid;
    logic                   item_stall;
    item_t                  item;
    logic                   result_valid;
    logic                   result_stall = 1'b0;
    result_t                result;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    int                     fail_count;
    int                     outstanding;

    // Stream position and register copies, kept to load entries before they are read
    bit          weight_loaded [WEIGHT_DEPTH];
    bit          bias_loaded [BIAS_DEPTH];
    int unsigned elem_at;
    int unsigned curve_at;
    int unsigned cell_at;
    logic        mirror_share;
    logic [3:0]  mirror_side;
    logic [6:0]  mirror_curves;
    logic [8:0]  mirror_len;

    int words_sent;
    int burst_left;
    int rx_mode = RX_FREE;
    int rx_left = 0;
    int cycles  = 0;

    curve_dot_product_layer_forward dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    curve_dot_product_checker dot_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .outstanding  (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("curve_dot_product_layer_forward: mismatch");
            $finish;
        end
    end

    // Receiver: switch between free, light and heavy stall stretches
    always @(negedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(RX_FREE, RX_HEAVY);
            rx_left = $urandom_range(5, 60);
        end
        else
        begin
            rx_left--;
        end
        case (rx_mode)
            RX_LIGHT: result_stall <= ($urandom_range(0, 3) == 0);
            RX_HEAVY: result_stall <= ($urandom_range(0, 3) != 0);
            default:  result_stall <= 1'b0;
        endcase
    end

    function automatic int unsigned cap(int unsigned v, int unsigned lo, int unsigned hi);
        if (v < lo)
        begin
            return lo;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    function automatic logic [15:0] pick_value();
        logic [15:0] v;
        case ($urandom_range(0, 9))
            0:       v = 16'h8000;
            1:       v = 16'h7FFF;
            2:       v = 16'($urandom_range(0, 15));
            3:       v = 16'(-$urandom_range(1, 16));
            default: v = 16'($urandom_range(0, 16'hFFFF));
        endcase
        return v;
    endfunction

    function automatic int unsigned one_of(int unsigned a, int unsigned b,
                                           int unsigned c, int unsigned d);
        case ($urandom_range(0, 3))
            0:       return a;
            1:       return b;
            2:       return c;
            default: return d;
        endcase
    endfunction

    // Send one word; start with a gap when the burst is spent. Call at a falling edge.
    task automatic put_word(input item_t w);
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 8);
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= w;
        do
            @(posedge clk);
        while (item_stall);
        @(negedge clk);
        burst_left--;
    endtask

    task automatic put_load(input logic [OPCODE_W-1:0] op, input logic [15:0] addr,
                            input logic [15:0] v);
        item_t w;
        w.opcode  = op;
        w.address = addr;
        w.value   = v;
        if (op == OP_LOAD_WEIGHT)
        begin
            weight_loaded[addr] = 1'b1;
        end
        else if (addr < BIAS_DEPTH)
        begin
            bias_loaded[addr] = 1'b1;
        end
        words_sent++;
        put_word(w);
    endtask

    task automatic put_noise(input logic [15:0] addr, input logic [15:0] v);
        item_t w;
        w.opcode  = OP_UNUSED;
        w.address = addr;
        w.value   = v;
        put_word(w);
    endtask

    // Send a data word, loading its weight (and, for a curve's last element, its bias) first if never written
    task automatic put_element(input logic [15:0] x);
        int unsigned len_eff;
        int unsigned curves_eff;
        int unsigned side_eff;
        int unsigned cells_eff;
        int unsigned slot;
        int unsigned waddr;
        logic last_el;
        item_t w;

        len_eff    = cap(32'(mirror_len), 1, 256);
        curves_eff = cap(32'(mirror_curves), 1, 64);
        side_eff   = cap(32'(mirror_side), 1, 8);
        cells_eff  = side_eff * side_eff * side_eff;
        slot       = mirror_share ? curve_at : cell_at * curves_eff + curve_at;
        waddr      = slot * len_eff + elem_at;
        last_el    = (elem_at + 1 >= len_eff);

        if (waddr < WEIGHT_DEPTH && !weight_loaded[waddr])
        begin
            put_load(OP_LOAD_WEIGHT, waddr[15:0], pick_value());
        end
        if (last_el && slot < BIAS_DEPTH && !bias_loaded[slot])
        begin
            put_load(OP_LOAD_BIAS, slot[15:0], pick_value());
        end

        w.opcode  = OP_DATA;
        w.address = 16'($urandom_range(0, 16'hFFFF));
        w.value   = x;
        words_sent++;
        put_word(w);

        // Advance the stream position
        if (!last_el)
        begin
            elem_at = (elem_at + 1) & 32'hFF;
        end
        else
        begin
            elem_at = 0;
            if (curve_at + 1 >= curves_eff)
            begin
                curve_at = 0;
                cell_at  = (cell_at + 1 >= cells_eff) ? 0 : ((cell_at + 1) & 32'h1FF);
            end
            else
            begin
                curve_at = (curve_at + 1) & 32'h3F;
            end
        end
    endtask

    // Write one register, with random bits above its width
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [15:0] v);
        logic [CFG_DATA_W-1:0] mask;
        case (index)
            CFG_SHARE_WEIGHTS:
            begin
                mask         = 16'h0001;
                mirror_share = v[0];
            end
            CFG_CELLS_PER_SIDE:
            begin
                mask        = 16'h000F;
                mirror_side = v[3:0];
            end
            CFG_CURVES_PER_CELL:
            begin
                mask          = 16'h007F;
                mirror_curves = v[6:0];
            end
            default:
            begin
                mask       = 16'h01FF;
                mirror_len = v[8:0];
            end
        endcase
        cfg_index <= index;
        cfg_data  <= (16'($urandom_range(0, 16'hFFFF)) & ~mask) | (v & mask);
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    task automatic set_shape(input int unsigned share, input int unsigned side,
                             input int unsigned curves, input int unsigned len);
        write_reg(CFG_SHARE_WEIGHTS, 16'(share));
        write_reg(CFG_CELLS_PER_SIDE, 16'(side));
        write_reg(CFG_CURVES_PER_CELL, 16'(curves));
        write_reg(CFG_DOT_LENGTH, 16'(len));
    endtask

    // Drop valid, wait for every expected word, then let the pipeline drain
    task automatic settle();
        item_valid <= 1'b0;
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    initial
    begin
        int phase;
        int count;
        int r;
        bit data_only;

        rst_n      = 1'b0;
        item_valid = 1'b0;
        item       = '0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_SHARE_WEIGHTS;
        cfg_data   = '0;

        words_sent    = 0;
        burst_left    = 0;
        elem_at       = 0;
        curve_at      = 0;
        cell_at       = 0;
        mirror_share  = 1'b1;
        mirror_side   = 4'd4;
        mirror_curves = 7'd8;
        mirror_len    = 9'd16;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: one cell of two curves, four elements each
        set_shape(1, 1, 2, 4);
        put_load(OP_LOAD_WEIGHT, 16'd0, 16'h8000);
        put_load(OP_LOAD_WEIGHT, 16'd1, 16'h8000);
        put_load(OP_LOAD_WEIGHT, 16'd2, 16'h7FFF);
        put_load(OP_LOAD_WEIGHT, 16'd3, 16'h7FFF);
        put_load(OP_LOAD_BIAS, 16'd0, 16'h7FFF);
        // Two most-negative squares overflow high
        put_element(16'h8000);
        put_element(16'h8000);
        put_element(16'h0000);
        put_element(16'h0001);
        // Four large negative products overflow low; last curve of the sample
        for (int i = 4; i < 8; i++)
        begin
            put_load(OP_LOAD_WEIGHT, i[15:0], 16'h7FFF);
        end
        put_load(OP_LOAD_BIAS, 16'd1, 16'h8000);
        for (int i = 0; i < 4; i++)
        begin
            put_element(16'h8000);
        end
        // Unused opcode, bias load past the store, weight at the top address
        put_noise(16'hFFFF, 16'h7FFF);
        put_load(OP_LOAD_BIAS, 16'hFFFF, 16'h1234);
        put_load(OP_LOAD_WEIGHT, 16'hFFFF, 16'h8001);
        settle();

        // Random phases; stream position carries over each register change
        phase = 0;
        while (words_sent < WORD_TARGET)
        begin
            phase++;
            data_only = 1'b0;
            count     = $urandom_range(15, 70);
            if (phase == 2)
            begin
                // Walk the cell index up cheaply through one shared slot
                set_shape(1, 8, 1, 1);
                count     = 80;
                data_only = 1'b1;
            end
            else if (phase == 3)
            begin
                // Private slots far past both stores
                set_shape(0, 8, 64, 256);
                count     = 20;
                data_only = 1'b1;
            end
            else if ($urandom_range(0, 4) == 0)
            begin
                set_shape($urandom_range(0, 1), one_of(0, 1, 8, 15),
                          one_of(0, 1, 64, 127), one_of(0, 1, 256, 511));
            end
            else
            begin
                set_shape($urandom_range(0, 1),
                          ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8)
                                                      : $urandom_range(1, 2),
                          ($urandom_range(0, 5) == 0) ? $urandom_range(1, 64)
                                                      : $urandom_range(1, 4),
                          ($urandom_range(0, 4) == 0) ? $urandom_range(9, 40)
                                                      : $urandom_range(1, 8));
            end

            for (int i = 0; i < count; i++)
            begin
                r = $urandom_range(0, 99);
                if (!data_only && r < 3)
                begin
                    put_noise(16'($urandom_range(0, 16'hFFFF)), pick_value());
                end
                else if (!data_only && r < 6)
                begin
                    put_load(OP_LOAD_WEIGHT, 16'($urandom_range(0, 16'hFFFF)), pick_value());
                end
                else if (!data_only && r < 9)
                begin
                    put_load(OP_LOAD_BIAS,
                             16'(($urandom_range(0, 1) == 0)
                                 ? $urandom_range(0, BIAS_DEPTH - 1)
                                 : $urandom_range(0, 16'hFFFF)),
                             pick_value());
                end
                else
                begin
                    put_element(pick_value());
                end
            end
            settle();
        end

        if (fail_count == 0)
        begin
            $display("curve_dot_product_layer_forward: match");
        end
        else
        begin
            $display("curve_dot_product_layer_forward: mismatch");
        end
        $finish;
    end

endmodule

### curve_dot_product_layer_forward.f
rtl/cdp_pkg.sv
rtl/curve_dot_product_layer_forward.sv
sim/curve_dot_product_checker.sv
sim/curve_dot_product_layer_forward_tb.sv
